FILE: hw/rtl/pdtc_pkg.sv
// Shared types, widths and codes for the press duration trigger classifier.
`default_nettype none

package pdtc_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int LIMIT_WIDTH    = 16;
  localparam int CMP_WIDTH      = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_ADDR_LSB   = 2;
  localparam int EVENT_WIDTH    = 3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LIMIT_WIDTH-1:0] limit_t;
  typedef logic [CMP_WIDTH-1:0]   cmp_t;

  localparam limit_t SHORT_LIMIT_RST = limit_t'(50);
  localparam limit_t HOLD_LIMIT_RST  = limit_t'(350);

  typedef enum logic [0:0] {
    REG_SHORT_LIMIT = 1'b0,
    REG_HOLD_LIMIT  = 1'b1
  } reg_idx_t;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_NONE          = 3'd0,
    EV_FOCUS_START   = 3'd1,
    EV_SHUTTER_START = 3'd2,
    EV_HOLD_START    = 3'd3,
    EV_HOLD_STOP     = 3'd4,
    EV_FOCUS_STOP    = 3'd5,
    EV_SHUTTER_STOP  = 3'd6
  } evt_t;

  typedef struct packed {
    limit_t short_limit;
    limit_t hold_limit;
  } limits_t;

  typedef struct packed {
    logic focus_level;
    logic shutter_level;
    evt_t evt;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pdtc_if.sv
// Valid/ready channel interfaces for tick beats in and result beats out.
`default_nettype none

interface pdtc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface pdtc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             focus_level;
  logic                             shutter_level;
  logic [pdtc_pkg::EVENT_WIDTH-1:0] event_code;

  modport source (output valid, output focus_level, output shutter_level,
                  output event_code, input ready);
  modport sink   (input valid, input focus_level, input shutter_level,
                  input event_code, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pdtc_cfg_regs.sv
// APB register file holding the short and hold limits.
`default_nettype none

module pdtc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pdtc_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [pdtc_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic      [pdtc_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                     pready,
  output pdtc_pkg::limits_t                        limits
);
  import pdtc_pkg::*;

  limit_t   short_limit_r;
  limit_t   hold_limit_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_LSB]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_limit_r <= SHORT_LIMIT_RST;
      hold_limit_r  <= HOLD_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHORT_LIMIT: short_limit_r <= pwdata[LIMIT_WIDTH-1:0];
        REG_HOLD_LIMIT:  hold_limit_r  <= pwdata[LIMIT_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SHORT_LIMIT: prdata = APB_DATA_WIDTH'(short_limit_r);
      REG_HOLD_LIMIT:  prdata = APB_DATA_WIDTH'(hold_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign limits.short_limit = short_limit_r;
  assign limits.hold_limit  = hold_limit_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pdtc_classifier.sv
// Press timing state and the per-tick classification of the button level.
`default_nettype none

module pdtc_classifier (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              button_level,
  input  pdtc_pkg::limits_t      limits,
  output pdtc_pkg::result_t      res_nxt
);
  import pdtc_pkg::*;

  logic   prev_level_r,    prev_level_nxt;
  count_t cnt_r,           cnt_nxt;
  logic   hold_active_r,   hold_active_nxt;
  logic   focus_active_r,  focus_active_nxt;
  logic   shut_active_r,   shut_active_nxt;
  logic   focus_drive_r,   focus_drive_nxt;
  logic   shut_drive_r,    shut_drive_nxt;
  evt_t   evt;

  count_t elapsed;
  cmp_t   elapsed_c;
  cmp_t   short_c;
  cmp_t   hold_c;

  // The count sticks at all ones rather than wrapping.
  assign elapsed   = (cnt_r == '1) ? cnt_r : cnt_r + count_t'(1);
  assign elapsed_c = cmp_t'(elapsed);
  assign short_c   = cmp_t'(limits.short_limit);
  assign hold_c    = cmp_t'(limits.hold_limit);

  always_comb begin
    prev_level_nxt   = prev_level_r;
    cnt_nxt          = cnt_r;
    hold_active_nxt  = hold_active_r;
    focus_active_nxt = focus_active_r;
    shut_active_nxt  = shut_active_r;
    focus_drive_nxt  = focus_drive_r;
    shut_drive_nxt   = shut_drive_r;
    evt              = EV_NONE;

    if (button_level != prev_level_r) begin
      prev_level_nxt = button_level;
      cnt_nxt        = '0;
      // A release is classified by the length of the press it ends.
      if (!button_level) begin
        if (elapsed_c < short_c) begin
          focus_active_nxt = 1'b1;
          focus_drive_nxt  = 1'b1;
          evt              = EV_FOCUS_START;
        end else if (elapsed_c <= hold_c) begin
          shut_active_nxt = 1'b1;
          shut_drive_nxt  = 1'b1;
          evt             = EV_SHUTTER_START;
        end else begin
          hold_active_nxt = 1'b0;
          shut_drive_nxt  = 1'b0;
          evt             = EV_HOLD_STOP;
        end
      end
    end else begin
      cnt_nxt = elapsed;
      if (button_level) begin
        if ((elapsed_c > hold_c) && !hold_active_r) begin
          hold_active_nxt = 1'b1;
          shut_drive_nxt  = 1'b1;
          evt             = EV_HOLD_START;
        end
      end else if (elapsed_c > short_c) begin
        // Idle long enough: focus is stopped first, shutter on a later tick.
        if (focus_active_r) begin
          focus_active_nxt = 1'b0;
          focus_drive_nxt  = 1'b0;
          evt              = EV_FOCUS_STOP;
        end else if (shut_active_r) begin
          shut_active_nxt = 1'b0;
          shut_drive_nxt  = 1'b0;
          evt             = EV_SHUTTER_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r   <= 1'b0;
      cnt_r          <= '0;
      hold_active_r  <= 1'b0;
      focus_active_r <= 1'b0;
      shut_active_r  <= 1'b0;
      focus_drive_r  <= 1'b0;
      shut_drive_r   <= 1'b0;
    end else if (step) begin
      prev_level_r   <= prev_level_nxt;
      cnt_r          <= cnt_nxt;
      hold_active_r  <= hold_active_nxt;
      focus_active_r <= focus_active_nxt;
      shut_active_r  <= shut_active_nxt;
      focus_drive_r  <= focus_drive_nxt;
      shut_drive_r   <= shut_drive_nxt;
    end
  end

  assign res_nxt.focus_level   = focus_drive_nxt;
  assign res_nxt.shutter_level = shut_drive_nxt;
  assign res_nxt.evt           = evt;

endmodule

`default_nettype wire

FILE: hw/rtl/pdtc_out_stage.sv
// Result register with valid/ready handshake towards the output channel.
`default_nettype none

module pdtc_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               take,
  input  pdtc_pkg::result_t  res_nxt,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pdtc_pkg::result_t  res_r
);
  import pdtc_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;

  // A new beat may enter whenever the held result leaves in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/press_duration_trigger_classifier.sv
// Top level of the press duration trigger classifier.
`default_nettype none

// Each input beat is one tick carrying the sampled button level; each accepted
// tick yields exactly one result beat with the focus and shutter drive levels
// after that tick and an event code. The block takes one tick per clock cycle
// and the result appears in the cycle after the tick is accepted: the whole
// classification is one pass of logic in front of a single result register,
// and the input stays ready whenever that register is empty or is being read
// in the same cycle. The short and hold limits sit in two APB registers at
// byte addresses 0 and 4; write them only while no tick is in flight.
module press_duration_trigger_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  pdtc_in_if.sink                                  in_ch,
  pdtc_out_if.source                               out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pdtc_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [pdtc_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic      [pdtc_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                     pready
);
  import pdtc_pkg::*;

  limits_t limits;
  result_t res_nxt;
  result_t res_r;
  logic    take;
  logic    in_ready;
  logic    out_valid;

  pdtc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  pdtc_classifier u_classifier (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (take),
    .button_level (in_ch.button_level),
    .limits       (limits),
    .res_nxt      (res_nxt)
  );

  pdtc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .take      (take),
    .res_nxt   (res_nxt),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res_r     (res_r)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.focus_level   = res_r.focus_level;
  assign out_ch.shutter_level = res_r.shutter_level;
  assign out_ch.event_code    = res_r.evt;

endmodule

`default_nettype wire

FILE: hw/rtl/pdtc_checker.sv
// Port-level assertions for the press duration trigger classifier, bound to the top level.
`default_nettype none

module pdtc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             focus_level,
  input wire logic                             shutter_level,
  input wire logic [pdtc_pkg::EVENT_WIDTH-1:0] event_code
);
  import pdtc_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(focus_level) && $stable(shutter_level) && $stable(event_code))
    else $error("result beat changed while stalled");

  // Every accepted tick leaves a result beat in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result beat");

  // The input is held off only while a result waits and is not being taken.
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the result register");

  // Start and stop events agree with the drive levels they report.
  a_event_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (event_code != EV_FOCUS_START   || focus_level) &&
      (event_code != EV_FOCUS_STOP    || !focus_level) &&
      (event_code != EV_SHUTTER_START || shutter_level) &&
      (event_code != EV_HOLD_START    || shutter_level) &&
      (event_code != EV_HOLD_STOP     || !shutter_level) &&
      (event_code != EV_SHUTTER_STOP  || !shutter_level))
    else $error("event code disagrees with drive levels");

endmodule

bind press_duration_trigger_classifier pdtc_checker u_pdtc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .focus_level   (out_ch.focus_level),
  .shutter_level (out_ch.shutter_level),
  .event_code    (out_ch.event_code)
);

`default_nettype wire
